FILE: design/hfa_pkg.sv
// Shared types and constants of the hole fit allocator.
package hfa_pkg;

    // Fixed widths of the stream fields
    localparam int IDX_FIELD_W  = 4;
    localparam int SIZE_FIELD_W = 20;
    localparam int TDATA_W      = 48;
    localparam int CFG_DATA_W   = 5;

    // Configuration register indexes
    localparam logic CFG_FIT_POLICY = 1'b0;
    localparam logic CFG_HOLE_COUNT = 1'b1;

    // Request kinds carried on tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Fit policy codes; the unused code behaves as first fit
    localparam logic [1:0] PLC_FIRST = 2'd0;
    localparam logic [1:0] PLC_BEST  = 2'd1;
    localparam logic [1:0] PLC_WORST = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } hfa_state_t;

endpackage

FILE: design/hole_fit_allocator_unit.sv
// Top level of the hole fit allocator: hole table memory, scan sequencer, result register.

// Hole fit allocator. Keeps NUM_HOLES hole capacities in a single-port-write,
// registered-read memory. A load transfer (s_tuser = load) writes one entry in the
// cycle it is accepted and gives no result. An allocate transfer starts a scan
// that reads one entry per cycle over the first hole_count entries (saturated
// to NUM_HOLES), keeping the candidate chosen by fit_policy: first fit, best fit
// or worst fit, ties going to the lowest index. The chosen entry is then
// written back shrunk by the request size and one result transfer is offered on
// the master side. The time of an allocate from acceptance to the result
// register is set by the one-entry-per-cycle read port of the table and its
// registered read, and grows with the active hole count. The slave side is
// ready whenever the sequencer is idle, even while an earlier result still
// waits on the master side. The table contents are undefined after reset
// until loaded. Configuration writes are expected only while the block is
// idle.
module hole_fit_allocator_unit
    import hfa_pkg::*;
#(
    parameter int NUM_HOLES  = 16,
    parameter int SIZE_WIDTH = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] load_index, [23:4] load_capacity, [43:24] req_size, [47:44] zero
    input  logic [TDATA_W-1:0]     s_tdata,
    // [0] req_type
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [3:0] hole_index, [23:4] size_before, [43:24] size_after, [47:44] zero
    output logic [TDATA_W-1:0]     m_tdata,
    // [0] fitted
    output logic [0:0]             m_tuser,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
    localparam int CNT_W = $clog2(NUM_HOLES + 1);

    // Configuration
    logic [1:0]            fit_policy_reg;
    logic [CFG_DATA_W-1:0] hole_count_reg;

    // Sequencer
    hfa_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      issue_reg;
    logic [CNT_W-1:0]      active_reg;
    logic                  pend_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_WIDTH-1:0] best_cap_reg;
    logic [SIZE_WIDTH-1:0] size_reg;

    // Memory
    logic [SIZE_WIDTH-1:0] hole_mem [NUM_HOLES];
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [SIZE_WIDTH-1:0] mem_wdata;
    logic                  mem_re;

    // Result register
    logic                  m_tvalid_reg;
    logic                  fitted_reg;
    logic [IDX_FIELD_W-1:0]  hole_index_reg;
    logic [SIZE_FIELD_W-1:0] size_before_reg;
    logic [SIZE_FIELD_W-1:0] size_after_reg;

    // Input field views
    logic                    req_type;
    logic [IDX_FIELD_W-1:0]  load_index;
    logic [SIZE_FIELD_W-1:0] load_capacity;
    logic [SIZE_FIELD_W-1:0] req_size;

    logic                  in_xfer;
    logic                  load_hit;
    logic                  out_free;
    logic                  take;
    logic [CNT_W-1:0]      active_calc;
    logic [SIZE_WIDTH-1:0] shrunk;

    assign req_type      = s_tuser[0];
    assign load_index    = s_tdata[3:0];
    assign load_capacity = s_tdata[23:4];
    assign req_size      = s_tdata[43:24];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Drop loads aimed beyond the table
    assign load_hit = (32'(load_index) < 32'(NUM_HOLES));

    // Saturate the active count to the table depth
    always_comb
    begin
        if (32'(hole_count_reg) > 32'(NUM_HOLES))
            active_calc = CNT_W'(NUM_HOLES);
        else
            active_calc = CNT_W'(hole_count_reg);
    end

    assign shrunk = best_cap_reg - size_reg;

    // Decide whether the entry just read replaces the current candidate
    always_comb
    begin
        take = 1'b0;
        if (pend_reg && (rd_data_reg >= size_reg))
        begin
            unique case (fit_policy_reg)
                PLC_BEST:  take = !found_reg || (rd_data_reg < best_cap_reg);
                PLC_WORST: take = !found_reg || (rd_data_reg > best_cap_reg);
                default:   take = !found_reg;
            endcase
        end
    end

    // Memory port control: loads in idle, write-back when the result leaves
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = IDX_W'(load_index);
        mem_wdata = SIZE_WIDTH'(load_capacity);
        if (in_xfer && (req_type == REQ_LOAD) && load_hit)
            mem_we = 1'b1;
        else if ((state_reg == ST_DONE) && out_free && found_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = shrunk;
        end
    end

    assign mem_re = (state_reg == ST_SCAN) && (issue_reg < active_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hole_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= hole_mem[issue_reg[IDX_W-1:0]];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (req_type == REQ_ALLOC))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!mem_re && !pend_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fit_policy_reg <= PLC_FIRST;
            hole_count_reg <= CFG_DATA_W'(16);
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            issue_reg      <= '0;
            active_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIT_POLICY: fit_policy_reg <= cfg_data[1:0];
                    CFG_HOLE_COUNT: hole_count_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Start a scan on an accepted allocate
            if (in_xfer && (req_type == REQ_ALLOC))
            begin
                issue_reg  <= '0;
                active_reg <= active_calc;
                found_reg  <= 1'b0;
                pend_reg   <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pend_reg <= mem_re;
                if (mem_re)
                    issue_reg <= issue_reg + CNT_W'(1);
                if (take)
                    found_reg <= 1'b1;
            end

            // Hold the result until the master side takes it
            if ((state_reg == ST_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer && (req_type == REQ_ALLOC))
            size_reg <= SIZE_WIDTH'(req_size);
        if ((state_reg == ST_SCAN) && mem_re)
            pend_idx_reg <= issue_reg[IDX_W-1:0];
        if ((state_reg == ST_SCAN) && take)
        begin
            best_idx_reg <= pend_idx_reg;
            best_cap_reg <= rd_data_reg;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            fitted_reg <= found_reg;
            if (found_reg)
            begin
                hole_index_reg  <= IDX_FIELD_W'(best_idx_reg);
                size_before_reg <= SIZE_FIELD_W'(best_cap_reg);
                size_after_reg  <= SIZE_FIELD_W'(shrunk);
            end
            else
            begin
                hole_index_reg  <= '0;
                size_before_reg <= '0;
                size_after_reg  <= '0;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = fitted_reg;
    assign m_tdata    = {4'd0, size_after_reg, size_before_reg, hole_index_reg};

`ifndef SYNTHESIS
    // A read in flight only exists while scanning
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("read pending outside scan");

    // The scan never runs past the active entries
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= active_reg))
        else $error("scan address beyond active count");

    // A chosen hole always holds the request
    a_fit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && found_reg) |-> (best_cap_reg >= size_reg))
        else $error("chosen hole smaller than request");

    // A result appears only straight after the write-back state
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside write-back");
`endif

endmodule
